// ----- rtl/stpa_pkg.sv -----
// Shared constants, types and the stereo downmix for the scope trigger averager.
package stpa_pkg;

  localparam int FRAME_LEN = 1024;
  localparam int AW        = $clog2(FRAME_LEN);
  localparam int SW        = 16;
  localparam int OW        = 10;
  localparam int PAW       = 4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] REG_TRIG_EN = 2'd0;
  localparam logic [1:0] REG_USE_EXT = 2'd1;
  localparam logic [1:0] REG_EXT_OFS = 2'd2;
  localparam logic [1:0] REG_SINGLE  = 2'd3;

  localparam logic signed [SW-1:0] C_OLD = 16'sd21299;
  localparam logic signed [SW-1:0] C_NEW = 16'sd11469;
  localparam int                   RND   = 16384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BLEND
  } state_t;

  typedef logic [AW-1:0]        addr_t;
  typedef logic signed [SW-1:0] smp_t;

  function automatic smp_t downmix(smp_t l, smp_t r, logic single);
    logic [SW:0]          a;
    logic [SW:0]          b;
    logic [SW+2:0]        a4;
    logic [SW+2:0]        b4;
    logic signed [SW:0]   s;
    smp_t                 res;
    a   = l[SW-1] ? ((SW+1)'(0) - {l[SW-1], l}) : {1'b0, l};
    b   = r[SW-1] ? ((SW+1)'(0) - {r[SW-1], r}) : {1'b0, r};
    a4  = {a, 2'b00};
    b4  = {b, 2'b00};
    s   = {l[SW-1], l} + {r[SW-1], r};
    if (single) begin
      res = l;
    end else if (a == '0 && b == '0) begin
      res = '0;
    end else if ({2'b00, a} >= b4) begin
      res = l;
    end else if ({2'b00, b} >= a4) begin
      res = r;
    end else begin
      res = s[SW:1];
    end
    return res;
  endfunction

endpackage

// ----- rtl/scope_trigger_persistence_averager.sv -----
// Top level: frame capture, trigger search and persistence blend over two memories.
//
// A load word is taken whenever start is high and busy is low. The load that
// completes a frame raises busy for one pass over the frame store: a
// rising-zero-crossing search (only when triggering is on and no external
// offset is used), then a blend that reads the frame store and the display
// store once per cycle each and writes the display store behind the read data
// register and the product register. A read word returns its result on the
// cycle after it is taken, with out_valid high for exactly that cycle; the
// receiver cannot stall. The display store reads as zero until the first frame
// has been blended, so no clearing pass follows reset.
module scope_trigger_persistence_averager
  import stpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic signed [SW-1:0] in_left_sample,
  input  logic signed [SW-1:0] in_right_sample,
  input  logic [OW-1:0]        in_read_index,
  output logic                 out_valid,
  output logic signed [SW-1:0] out_display_value,
  output logic [OW-1:0]        out_found_offset,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PAW-1:0]       paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam addr_t LAST = AW'(FRAME_LEN - 1);

  function automatic addr_t adv(addr_t a);
    return (a == LAST) ? '0 : a + AW'(1);
  endfunction

  state_t state_r, state_nxt;

  logic            trig_en_r, trig_en_nxt;
  logic            use_ext_r, use_ext_nxt;
  logic [OW-1:0]   ext_ofs_r, ext_ofs_nxt;
  logic            single_r, single_nxt;

  addr_t           load_cnt_r, load_cnt_nxt;
  addr_t           last_ofs_r, last_ofs_nxt;
  logic            disp_valid_r, disp_valid_nxt;
  addr_t           align_r, align_nxt;
  addr_t           iss_r, iss_nxt;
  addr_t           dat_idx_r, dat_idx_nxt;
  logic            dv_r, dv_nxt;
  logic            prev_neg_r, prev_neg_nxt;
  addr_t           blk_i_r, blk_i_nxt;
  addr_t           blk_k_r, blk_k_nxt;
  logic            blk_done_r, blk_done_nxt;
  logic            p1_v_r, p1_v_nxt;
  addr_t           p1_i_r, p1_i_nxt;
  logic            p2_v_r, p2_v_nxt;
  addr_t           p2_i_r, p2_i_nxt;
  logic signed [31:0] prod_old_r, prod_old_nxt;
  logic signed [31:0] prod_new_r, prod_new_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            rd_zero_r, rd_zero_nxt;

  smp_t            frame_mem [FRAME_LEN];
  smp_t            disp_mem  [FRAME_LEN];
  logic            fr_we;
  smp_t            fr_wdata;
  addr_t           fr_raddr;
  smp_t            fr_rd_r;
  logic            dp_we;
  smp_t            dp_wdata;
  addr_t           dp_raddr;
  smp_t            dp_rd_r;

  logic            accept;
  logic            ld;
  logic            rdq;
  logic            cfg_wr;
  addr_t           ext_mod;
  smp_t            old_v;
  logic signed [32:0] sum;

  assign accept   = start && !busy;
  assign ld       = accept && (in_mode == MODE_LOAD);
  assign rdq      = accept && (in_mode == MODE_READ);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign ext_mod  = AW'(32'(ext_ofs_r) % FRAME_LEN);
  assign fr_we    = ld;
  assign fr_wdata = downmix(in_left_sample, in_right_sample, single_r);
  assign fr_raddr = (state_r == ST_BLEND) ? blk_k_r : iss_r;
  assign dp_raddr = (state_r == ST_BLEND) ? blk_i_r : AW'(in_read_index);
  assign old_v    = disp_valid_r ? dp_rd_r : '0;
  assign sum      = 33'(prod_old_r) + 33'(prod_new_r) + 33'(RND);
  assign dp_wdata = sum[30:15];

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_display_value = rd_zero_r ? '0 : dp_rd_r;
  assign out_found_offset  = OW'(last_ofs_r);
  assign pready            = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_TRIG_EN: prdata = 32'(trig_en_r);
      REG_USE_EXT: prdata = 32'(use_ext_r);
      REG_EXT_OFS: prdata = 32'(ext_ofs_r);
      REG_SINGLE:  prdata = 32'(single_r);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    trig_en_nxt    = trig_en_r;
    use_ext_nxt    = use_ext_r;
    ext_ofs_nxt    = ext_ofs_r;
    single_nxt     = single_r;
    load_cnt_nxt   = load_cnt_r;
    last_ofs_nxt   = last_ofs_r;
    disp_valid_nxt = disp_valid_r;
    align_nxt      = align_r;
    iss_nxt        = iss_r;
    dat_idx_nxt    = dat_idx_r;
    dv_nxt         = dv_r;
    prev_neg_nxt   = prev_neg_r;
    blk_i_nxt      = blk_i_r;
    blk_k_nxt      = blk_k_r;
    blk_done_nxt   = blk_done_r;
    p1_v_nxt       = 1'b0;
    p1_i_nxt       = p1_i_r;
    p2_v_nxt       = 1'b0;
    p2_i_nxt       = p2_i_r;
    prod_old_nxt   = prod_old_r;
    prod_new_nxt   = prod_new_r;
    out_valid_nxt  = rdq;
    rd_zero_nxt    = rd_zero_r;
    dp_we          = 1'b0;

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_TRIG_EN: trig_en_nxt = pwdata[0];
        REG_USE_EXT: use_ext_nxt = pwdata[0];
        REG_EXT_OFS: ext_ofs_nxt = pwdata[OW-1:0];
        REG_SINGLE:  single_nxt  = pwdata[0];
        default:     ;
      endcase
    end

    if (rdq) begin
      rd_zero_nxt = !disp_valid_r || (32'(in_read_index) >= 32'(FRAME_LEN));
    end

    case (state_r)
      ST_IDLE: begin
        if (ld) begin
          if (load_cnt_r == LAST) begin
            load_cnt_nxt = '0;
            iss_nxt      = '0;
            dv_nxt       = 1'b0;
            prev_neg_nxt = 1'b0;
            blk_i_nxt    = '0;
            blk_done_nxt = 1'b0;
            if (trig_en_r && !use_ext_r) begin
              state_nxt = ST_SEARCH;
            end else begin
              align_nxt = trig_en_r ? ext_mod : '0;
              blk_k_nxt = trig_en_r ? ext_mod : '0;
              state_nxt = ST_BLEND;
            end
          end else begin
            load_cnt_nxt = adv(load_cnt_r);
          end
        end
      end
      ST_SEARCH: begin
        iss_nxt     = adv(iss_r);
        dat_idx_nxt = iss_r;
        dv_nxt      = 1'b1;
        if (dv_r) begin
          prev_neg_nxt = fr_rd_r[SW-1];
          if (dat_idx_r != '0 && prev_neg_r && !fr_rd_r[SW-1]) begin
            align_nxt = dat_idx_r;
            blk_k_nxt = dat_idx_r;
            state_nxt = ST_BLEND;
          end else if (dat_idx_r == LAST) begin
            align_nxt = '0;
            blk_k_nxt = '0;
            state_nxt = ST_BLEND;
          end
        end
      end
      ST_BLEND: begin
        if (!blk_done_r) begin
          p1_v_nxt  = 1'b1;
          p1_i_nxt  = blk_i_r;
          blk_i_nxt = adv(blk_i_r);
          blk_k_nxt = adv(blk_k_r);
          if (blk_i_r == LAST) begin
            blk_done_nxt = 1'b1;
          end
        end
        p2_v_nxt     = p1_v_r;
        p2_i_nxt     = p1_i_r;
        prod_old_nxt = 32'(old_v) * 32'(C_OLD);
        prod_new_nxt = 32'(fr_rd_r) * 32'(C_NEW);
        if (p2_v_r) begin
          dp_we = 1'b1;
          if (p2_i_r == LAST) begin
            last_ofs_nxt   = align_r;
            disp_valid_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_en_r    <= 1'b0;
      use_ext_r    <= 1'b0;
      ext_ofs_r    <= '0;
      single_r     <= 1'b0;
      load_cnt_r   <= '0;
      last_ofs_r   <= '0;
      disp_valid_r <= 1'b0;
      dv_r         <= 1'b0;
      blk_done_r   <= 1'b0;
      p1_v_r       <= 1'b0;
      p2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      trig_en_r    <= trig_en_nxt;
      use_ext_r    <= use_ext_nxt;
      ext_ofs_r    <= ext_ofs_nxt;
      single_r     <= single_nxt;
      load_cnt_r   <= load_cnt_nxt;
      last_ofs_r   <= last_ofs_nxt;
      disp_valid_r <= disp_valid_nxt;
      dv_r         <= dv_nxt;
      blk_done_r   <= blk_done_nxt;
      p1_v_r       <= p1_v_nxt;
      p2_v_r       <= p2_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    align_r    <= align_nxt;
    iss_r      <= iss_nxt;
    dat_idx_r  <= dat_idx_nxt;
    prev_neg_r <= prev_neg_nxt;
    blk_i_r    <= blk_i_nxt;
    blk_k_r    <= blk_k_nxt;
    p1_i_r     <= p1_i_nxt;
    p2_i_r     <= p2_i_nxt;
    prod_old_r <= prod_old_nxt;
    prod_new_r <= prod_new_nxt;
    rd_zero_r  <= rd_zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[load_cnt_r] <= fr_wdata;
    end
    fr_rd_r <= frame_mem[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      disp_mem[p2_i_r] <= dp_wdata;
    end
    dp_rd_r <= disp_mem[dp_raddr];
  end

endmodule

// ----- rtl/stpa_checker.sv -----
// Port-level checker for the scope trigger averager, bound to the top level.
module stpa_checker
  import stpa_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_mode,
  input logic                 out_valid,
  input logic [OW-1:0]        out_found_offset
);

  a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_READ) |=> out_valid)
    else $error("read word without result");

  a_word_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_mode == MODE_READ))
    else $error("result word without read");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_mode == MODE_LOAD))
    else $error("busy raised without load");

  a_offset_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(!busy)) |-> $stable(out_found_offset))
    else $error("offset changed while idle");

endmodule

bind scope_trigger_persistence_averager stpa_checker u_stpa_checker (.*);

// ----- dv/stpa_display_checker.sv -----
// Display predictor and result checker for the scope trigger persistence averager.
module stpa_display_checker
  import stpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_mode,
  input  logic signed [SW-1:0] in_left_sample,
  input  logic signed [SW-1:0] in_right_sample,
  input  logic [OW-1:0]        in_read_index,
  input  logic                 out_valid,
  input  logic signed [SW-1:0] out_display_value,
  input  logic [OW-1:0]        out_found_offset,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PAW-1:0]       paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    smp_t           value;
    logic [OW-1:0]  offset;
  } readout_t;

  readout_t      readout_q[$];
  readout_t      want;
  smp_t          frame_mem[FRAME_LEN];
  smp_t          display_mem[FRAME_LEN];
  int unsigned   fill_count;
  logic [OW-1:0] last_align;
  logic          trig_en;
  logic          use_ext;
  logic          single_ch;
  logic [OW-1:0] ext_ofs;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(string msg);
    if (errors < 200) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic smp_t mix_to_mono(smp_t l, smp_t r, logic left_only);
    int li;
    int ri;
    int la;
    int ra;
    li = l;
    ri = r;
    la = (li < 0) ? -li : li;
    ra = (ri < 0) ? -ri : ri;
    if (left_only) return l;
    if (la == 0 && ra == 0) return '0;
    if (la >= 4 * ra) return l;
    if (ra >= 4 * la) return r;
    return smp_t'((li + ri) >>> 1);
  endfunction

  function automatic smp_t persist(smp_t old, smp_t fresh);
    longint acc;
    acc = 64'sd21299 * longint'(old) + 64'sd11469 * longint'(fresh) + 64'sd16384;
    return smp_t'(acc >>> 15);
  endfunction

  function automatic void close_frame();
    int unsigned shift;
    int unsigned i;
    shift = 0;
    if (trig_en) begin
      if (use_ext) begin
        shift = int'(ext_ofs) % FRAME_LEN;
      end else begin
        for (i = 1; i < FRAME_LEN; i++) begin
          if (frame_mem[i-1] < 0 && frame_mem[i] >= 0) begin
            shift = i;
            break;
          end
        end
      end
    end
    for (i = 0; i < FRAME_LEN; i++) begin
      display_mem[i] = persist(display_mem[i], frame_mem[(i + shift) % FRAME_LEN]);
    end
    last_align = shift[OW-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      readout_q.delete();
      foreach (frame_mem[i]) frame_mem[i] = '0;
      foreach (display_mem[i]) display_mem[i] = '0;
      fill_count = 0;
      last_align = '0;
      trig_en    = 1'b0;
      use_ext    = 1'b0;
      single_ch  = 1'b0;
      ext_ofs    = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TRIG_EN: trig_en   = pwdata[0];
          REG_USE_EXT: use_ext   = pwdata[0];
          REG_EXT_OFS: ext_ofs   = pwdata[OW-1:0];
          REG_SINGLE:  single_ch = pwdata[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_mode == MODE_LOAD) begin
          frame_mem[fill_count] = mix_to_mono(in_left_sample, in_right_sample, single_ch);
          fill_count++;
          if (fill_count >= FRAME_LEN) begin
            close_frame();
            fill_count = 0;
          end
        end else begin
          want.value  = (in_read_index < FRAME_LEN) ? display_mem[in_read_index] : '0;
          want.offset = last_align;
          readout_q.push_back(want);
        end
      end
      if (out_valid) begin
        if (readout_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing outstanding: value %0d offset %0d",
                                    out_display_value, out_found_offset));
        end else begin
          want = readout_q.pop_front();
          if (out_display_value !== want.value) begin
            report_mismatch($sformatf("display_value got %0d expected %0d",
                                      out_display_value, want.value));
          end
          if (out_found_offset !== want.offset) begin
            report_mismatch($sformatf("found_offset got %0d expected %0d",
                                      out_found_offset, want.offset));
          end
        end
      end
    end
    pending = readout_q.size();
  end

endmodule

// ----- dv/scope_trigger_persistence_averager_test.sv -----
// Stimulus and verdict for the scope trigger persistence averager.
module scope_trigger_persistence_averager_test;
  import stpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int FRAME_SETTLE = 2200;
  localparam int READ_TAIL    = 200;

  typedef enum int {
    WAVE_NOISE,
    WAVE_CROSS,
    WAVE_NOCROSS
  } wave_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_mode;
  logic signed [SW-1:0] in_left_sample;
  logic signed [SW-1:0] in_right_sample;
  logic [OW-1:0]        in_read_index;
  logic                 out_valid;
  logic signed [SW-1:0] out_display_value;
  logic [OW-1:0]        out_found_offset;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PAW-1:0]       paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  int                   fail_count;
  int                   words_owed;
  int                   cycles;
  logic                 single_now;
  logic                 gappy;
  int                   burst_left;
  wave_t                frame_wave;

  scope_trigger_persistence_averager dut (.*);

  stpa_display_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_mode, .in_left_sample, .in_right_sample,
    .in_read_index, .out_valid, .out_display_value, .out_found_offset,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors(fail_count), .pending(words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic mode, smp_t l, smp_t r, logic [OW-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gappy      = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(16, 128);
    end
    burst_left--;
    gap = gappy ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_read_index   <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic issue_read();
    logic [OW-1:0] idx;
    case ($urandom_range(0, 5))
      0:       idx = '0;
      1:       idx = '1;
      default: idx = OW'($urandom);
    endcase
    send_word(MODE_READ, smp_t'($urandom), smp_t'($urandom), idx);
  endtask

  task automatic cfg_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(logic trig, logic ext, logic [OW-1:0] ofs, logic single);
    start <= 1'b0;
    while (words_owed != 0) @(posedge clk);
    repeat (FRAME_SETTLE) @(posedge clk);
    cfg_write(REG_TRIG_EN, {31'd0, trig});
    cfg_write(REG_USE_EXT, {31'd0, ext});
    cfg_write(REG_EXT_OFS, {22'd0, ofs});
    cfg_write(REG_SINGLE, {31'd0, single});
    single_now = single;
  endtask

  // shape the pair so the downmix lands exactly on the wanted mono value
  task automatic load_mono(int v);
    int m;
    int k;
    smp_t r;
    if (single_now) begin
      r = smp_t'($urandom);
    end else begin
      m = ((v < 0) ? -v : v) >> 2;
      k = $urandom_range(0, m);
      r = smp_t'($urandom_range(0, 1) ? k : -k);
    end
    send_word(MODE_LOAD, smp_t'(v), r, OW'($urandom));
  endtask

  function automatic int pos_val();
    return $urandom_range(0, 32767);
  endfunction

  function automatic int neg_val();
    return -int'($urandom_range(1, 32768));
  endfunction

  task automatic run_frame(wave_t wave, int cross_at, int first, int stop);
    int p;
    for (p = first; p < stop; p++) begin
      if ($urandom_range(0, 7) == 0) issue_read();
      case (wave)
        WAVE_NOISE: send_word(MODE_LOAD, smp_t'($urandom), smp_t'($urandom), OW'($urandom));
        WAVE_CROSS: begin
          if (p < cross_at - 1)       load_mono(pos_val());
          else if (p == cross_at - 1) load_mono(neg_val());
          else if (p == cross_at)     load_mono($urandom_range(0, 1) ? 0 : pos_val());
          else                        load_mono(int'($urandom_range(0, 65535)) - 32768);
        end
        default: load_mono((p < FRAME_LEN / 2) ? pos_val() : neg_val());
      endcase
    end
  endtask

  int dir_l[13] = '{0, 4, -4, 1, 8192, -3, -32768, 32767, -32768, -32768, 0, 3, -32768};
  int dir_r[13] = '{0, 1, 1, -4, -2048, -2, -32768, 32767, 32767, 0, 32767, 5, 8192};

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_LOAD;
    in_left_sample  = '0;
    in_right_sample = '0;
    in_read_index   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    single_now      = 1'b0;
    gappy           = 1'b0;
    burst_left      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(MODE_READ, '0, '0, '0);
    send_word(MODE_READ, '1, '1, '1);

    set_mode(($urandom_range(0, 4) != 0), ($urandom_range(0, 3) == 0), OW'($urandom),
             ($urandom_range(0, 3) == 0));
    frame_wave = wave_t'($urandom_range(0, 2));
    run_frame(frame_wave, $urandom_range(1, FRAME_LEN - $size(dir_l) - 1), 0,
              FRAME_LEN - $size(dir_l));
    foreach (dir_l[i]) send_word(MODE_LOAD, smp_t'(dir_l[i]), smp_t'(dir_r[i]), '0);
    send_word(MODE_READ, '0, '0, 10'd512);
    repeat (READ_TAIL) issue_read();

    start <= 1'b0;
    while (words_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/stpa_pkg.sv
rtl/scope_trigger_persistence_averager.sv
rtl/stpa_checker.sv
dv/stpa_display_checker.sv
dv/scope_trigger_persistence_averager_test.sv
